FILE: sv/tsil_pkg.sv
package tsil_pkg;

    localparam int TABLE_ROWS   = 1024;
    localparam int MAX_CHANNELS = 16;
    localparam int ROW_WORDS    = MAX_CHANNELS + 1;
    localparam int RAM_DEPTH    = TABLE_ROWS * ROW_WORDS;
    localparam int RAM_AW       = $clog2(RAM_DEPTH);
    localparam int ROW_W        = $clog2(TABLE_ROWS);
    localparam int ROWS_W       = $clog2(TABLE_ROWS + 1);
    localparam int COL_W        = $clog2(ROW_WORDS);
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int DATA_W       = 32;
    localparam int APB_AW       = 4;

    localparam logic [1:0] REG_ROW_COUNT     = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_INTERPOLATE   = 2'd2;

    localparam logic [1:0] HSEL_ZERO = 2'd0;
    localparam logic [1:0] HSEL_RAM  = 2'd1;
    localparam logic [1:0] HSEL_LERP = 2'd2;

    typedef struct packed {
        logic [ROWS_W-1:0] rows;
        logic [CNT_W-1:0]  chans;
        logic              interp;
    } t_cfg;

    typedef struct packed {
        logic             ram_wr;
        logic             ram_rd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             cap_t;
        logic             cap_ta;
        logic             cap_tb;
        logic             cap_y0;
        logic             lerp_start;
        logic             held_we;
        logic [1:0]       held_sel;
        logic [CH_W-1:0]  idx;
    } t_dp_cmd;

    typedef struct packed {
        logic t_ge_ta;
        logic t_le_rd;
        logic lerp_done;
    } t_dp_sts;

endpackage

FILE: sv/tsil_ram.sv
module tsil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tsil_lerp.sv
module tsil_lerp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tsil_pkg::DATA_W-1:0] i_ta,
    input  logic [tsil_pkg::DATA_W-1:0] i_tb,
    input  logic [tsil_pkg::DATA_W-1:0] i_t,
    input  logic [tsil_pkg::DATA_W-1:0] i_y0,
    input  logic [tsil_pkg::DATA_W-1:0] i_y1,
    output logic                        o_done,
    output logic [tsil_pkg::DATA_W-1:0] o_result
);
    import tsil_pkg::*;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;
    localparam logic [1:0] P_FIN  = 2'd3;

    logic [1:0]            r_phase;
    logic [5:0]            r_cnt;
    logic [DATA_W-1:0]     r_span;
    logic [DATA_W-1:0]     r_off;
    logic [DATA_W-1:0]     r_mag;
    logic                  r_neg;
    logic                  r_zero;
    logic [DATA_W-1:0]     r_y0;
    logic [2*DATA_W-1:0]   r_quo;
    logic [DATA_W-1:0]     r_rem;
    logic [DATA_W-1:0]     r_res;
    logic                  r_done;

    logic [DATA_W:0]       w_span;
    logic [DATA_W:0]       w_off;
    logic [DATA_W:0]       w_dy;
    logic [DATA_W:0]       w_ndy;
    logic [2*DATA_W-1:0]   w_prod;
    logic [DATA_W:0]       w_trial;
    logic                  w_fits;
    logic                  w_round;
    logic [DATA_W:0]       w_q;
    logic [DATA_W+1:0]     w_sum;

    assign w_span  = {i_tb[DATA_W-1], i_tb} - {i_ta[DATA_W-1], i_ta};
    assign w_off   = {i_t[DATA_W-1], i_t} - {i_ta[DATA_W-1], i_ta};
    assign w_dy    = {i_y1[DATA_W-1], i_y1} - {i_y0[DATA_W-1], i_y0};
    assign w_ndy   = -w_dy;
    assign w_prod  = r_mag * r_off;
    assign w_trial = {r_rem, r_quo[2*DATA_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_span};
    assign w_round = {r_rem, 1'b0} >= {1'b0, r_span};
    assign w_q     = r_quo[DATA_W:0] + {{DATA_W{1'b0}}, w_round};
    assign w_sum   = r_neg ? ({{2{r_y0[DATA_W-1]}}, r_y0} - {1'b0, w_q})
                           : ({{2{r_y0[DATA_W-1]}}, r_y0} + {1'b0, w_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_MUL;
                    end
                end
                P_MUL: begin
                    r_phase <= P_DIV;
                end
                P_DIV: begin
                    if (r_cnt == 6'd63) begin
                        r_phase <= P_FIN;
                    end
                end
                P_FIN: begin
                    r_done  <= 1'b1;
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            P_IDLE: begin
                r_span <= w_span[DATA_W-1:0];
                r_off  <= w_off[DATA_W-1:0];
                r_neg  <= w_dy[DATA_W];
                r_mag  <= w_dy[DATA_W] ? w_ndy[DATA_W-1:0] : w_dy[DATA_W-1:0];
                r_zero <= w_span == '0;
                r_y0   <= i_y0;
            end
            P_MUL: begin
                r_quo <= w_prod;
                r_rem <= '0;
                r_cnt <= '0;
            end
            P_DIV: begin
                r_cnt <= r_cnt + 6'd1;
                r_quo <= {r_quo[2*DATA_W-2:0], w_fits};
                r_rem <= w_fits ? 32'(w_trial - {1'b0, r_span}) : w_trial[DATA_W-1:0];
            end
            P_FIN: begin
                r_res <= r_zero ? r_y0 : w_sum[DATA_W-1:0];
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

FILE: sv/tsil_dp.sv
module tsil_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tsil_pkg::t_dp_cmd           i_cmd,
    input  logic [tsil_pkg::DATA_W-1:0] i_entry_value,
    input  logic [tsil_pkg::DATA_W-1:0] i_query_time,
    output tsil_pkg::t_dp_sts           o_sts,
    output logic [tsil_pkg::DATA_W-1:0] o_sample
);
    import tsil_pkg::*;

    logic [DATA_W-1:0] r_t;
    logic [DATA_W-1:0] r_ta;
    logic [DATA_W-1:0] r_tb;
    logic [DATA_W-1:0] r_y0;
    logic [DATA_W-1:0] r_held [MAX_CHANNELS];
    logic [DATA_W-1:0] w_rdata;
    logic [RAM_AW-1:0] w_addr;
    logic [DATA_W-1:0] w_lerp;
    logic              w_lerp_done;
    logic [DATA_W-1:0] w_held_d;

    assign w_addr = RAM_AW'(i_cmd.row) * RAM_AW'(ROW_WORDS) + RAM_AW'(i_cmd.col);

    tsil_ram #(
        .WIDTH(DATA_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.ram_wr),
        .i_re   (i_cmd.ram_rd),
        .i_addr (w_addr),
        .i_wdata(i_entry_value),
        .o_rdata(w_rdata)
    );

    tsil_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.lerp_start),
        .i_ta    (r_ta),
        .i_tb    (r_tb),
        .i_t     (r_t),
        .i_y0    (r_y0),
        .i_y1    (w_rdata),
        .o_done  (w_lerp_done),
        .o_result(w_lerp)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_t) begin
            r_t <= i_query_time;
        end
        if (i_cmd.cap_ta) begin
            r_ta <= w_rdata;
        end
        if (i_cmd.cap_tb) begin
            r_tb <= w_rdata;
        end
        if (i_cmd.cap_y0) begin
            r_y0 <= w_rdata;
        end
    end

    always_comb begin
        case (i_cmd.held_sel)
            HSEL_RAM:  w_held_d = w_rdata;
            HSEL_LERP: w_held_d = w_lerp;
            default:   w_held_d = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                r_held[k] <= '0;
            end
        end else if (i_cmd.held_we) begin
            r_held[i_cmd.idx] <= w_held_d;
        end
    end

    assign o_sts.t_ge_ta   = $signed(r_t) >= $signed(r_ta);
    assign o_sts.t_le_rd   = $signed(r_t) <= $signed(w_rdata);
    assign o_sts.lerp_done = w_lerp_done;
    assign o_sample        = r_held[i_cmd.idx];

endmodule

FILE: sv/tsil_ctrl.sv
module tsil_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tsil_pkg::t_cfg             i_cfg,
    input  logic                       i_in_valid,
    input  logic                       i_in_mode,
    input  logic [tsil_pkg::ROW_W-1:0] i_in_row,
    input  logic [tsil_pkg::COL_W-1:0] i_in_col,
    input  logic                       i_out_ready,
    input  tsil_pkg::t_dp_sts          i_sts,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    output logic                       o_out_last,
    output tsil_pkg::t_dp_cmd          o_cmd
);
    import tsil_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ZERO    = 4'd1;
    localparam logic [3:0] S_CAP_TA  = 4'd2;
    localparam logic [3:0] S_NEXT    = 4'd3;
    localparam logic [3:0] S_CMP     = 4'd4;
    localparam logic [3:0] S_LASTCHK = 4'd5;
    localparam logic [3:0] S_SEG     = 4'd6;
    localparam logic [3:0] S_Y0      = 4'd7;
    localparam logic [3:0] S_Y1      = 4'd8;
    localparam logic [3:0] S_LERP    = 4'd9;
    localparam logic [3:0] S_OUT     = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [ROW_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic             r_hold, n_hold;
    logic [3:0]       w_exit;
    logic [ROWS_W:0]  w_i_next;
    logic [CNT_W-1:0] w_j_inc;

    assign w_exit   = (i_cfg.chans == '0) ? S_IDLE : S_OUT;
    assign w_i_next = (ROWS_W + 1)'(r_i) + 1'b1;
    assign w_j_inc  = r_j + 1'b1;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_hold  = r_hold;
        o_cmd   = '0;
        o_cmd.idx = r_j[CH_W-1:0];
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.row  = i_in_row;
                o_cmd.col  = i_in_col;
                if (i_in_valid) begin
                    if (!i_in_mode) begin
                        o_cmd.ram_wr = i_in_col <= COL_W'(MAX_CHANNELS);
                    end else begin
                        o_cmd.cap_t  = 1'b1;
                        o_cmd.ram_rd = 1'b1;
                        o_cmd.row    = '0;
                        o_cmd.col    = '0;
                        n_i = '0;
                        n_j = '0;
                        n_state = (i_cfg.rows == '0) ? S_ZERO : S_CAP_TA;
                    end
                end
            end
            S_ZERO: begin
                if (r_j == i_cfg.chans) begin
                    n_j = '0;
                    n_state = w_exit;
                end else begin
                    o_cmd.held_we  = 1'b1;
                    o_cmd.held_sel = HSEL_ZERO;
                    n_j = w_j_inc;
                end
            end
            S_CAP_TA: begin
                o_cmd.cap_ta = 1'b1;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (w_i_next < (ROWS_W + 1)'(i_cfg.rows)) begin
                    o_cmd.ram_rd = 1'b1;
                    o_cmd.row    = w_i_next[ROW_W-1:0];
                    o_cmd.col    = '0;
                    n_state = S_CMP;
                end else begin
                    n_state = S_LASTCHK;
                end
            end
            S_CMP: begin
                if (i_sts.t_ge_ta && i_sts.t_le_rd) begin
                    o_cmd.cap_tb = 1'b1;
                    n_hold  = !i_cfg.interp;
                    n_j     = '0;
                    n_state = S_SEG;
                end else begin
                    o_cmd.cap_ta = 1'b1;
                    n_i     = w_i_next[ROW_W-1:0];
                    n_state = S_NEXT;
                end
            end
            S_LASTCHK: begin
                n_j = '0;
                if (i_sts.t_ge_ta) begin
                    n_hold  = 1'b1;
                    n_state = S_SEG;
                end else begin
                    n_state = w_exit;
                end
            end
            S_SEG: begin
                if (r_j == i_cfg.chans) begin
                    n_j = '0;
                    n_state = w_exit;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    o_cmd.row    = r_i;
                    o_cmd.col    = COL_W'(w_j_inc);
                    n_state = S_Y0;
                end
            end
            S_Y0: begin
                if (r_hold) begin
                    o_cmd.held_we  = 1'b1;
                    o_cmd.held_sel = HSEL_RAM;
                    n_j = w_j_inc;
                    n_state = S_SEG;
                end else begin
                    o_cmd.cap_y0 = 1'b1;
                    o_cmd.ram_rd = 1'b1;
                    o_cmd.row    = w_i_next[ROW_W-1:0];
                    o_cmd.col    = COL_W'(w_j_inc);
                    n_state = S_Y1;
                end
            end
            S_Y1: begin
                o_cmd.lerp_start = 1'b1;
                n_state = S_LERP;
            end
            S_LERP: begin
                if (i_sts.lerp_done) begin
                    o_cmd.held_we  = 1'b1;
                    o_cmd.held_sel = HSEL_LERP;
                    n_j = w_j_inc;
                    n_state = S_SEG;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_out_last  = w_j_inc == i_cfg.chans;
                if (i_out_ready) begin
                    if (o_out_last) begin
                        n_j = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_j = w_j_inc;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_hold  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_hold  <= n_hold;
        end
    end

endmodule

FILE: sv/time_series_interp_lookup.sv
// Piecewise linear lookup over a loaded time series table. A beat with tuser low writes one
// table entry (column 0 is the row time, columns 1 to 16 the Q16.16 samples), and the block
// stays ready for the next beat. A beat with tuser high is a query; it returns one beat per
// channel, the last one marked by tlast, and no further beat is taken until those are
// delivered. A query scans the row times from row 0 through the single port of the table
// memory. Each channel is then copied from the found row when samples are held, or
// interpolated through the 64-step divider. The table holds up to 1024 rows.
module time_series_interp_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsil_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: row[9:0], column[14:10], entry_value[46:15], query_time[78:47].
    input  logic [79:0]                   s_axis_tdata,
    // Fields from bit 0: mode.
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: channel[3:0], sample[35:4].
    output logic [39:0]                   m_axis_tdata,
    output logic                          m_axis_tlast
);
    import tsil_pkg::*;

    logic [ROWS_W-1:0] r_row_count;
    logic [CNT_W-1:0]  r_channel_count;
    logic              r_interp;
    logic              w_wr;
    t_cfg              w_cfg;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [DATA_W-1:0] w_sample;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= '0;
            r_channel_count <= '0;
            r_interp        <= 1'b0;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_ROW_COUNT:     r_row_count     <= pwdata[ROWS_W-1:0];
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[CNT_W-1:0];
                REG_INTERPOLATE:   r_interp        <= pwdata[0];
                default:           r_interp        <= r_interp;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROW_COUNT:     prdata = 32'(r_row_count);
            REG_CHANNEL_COUNT: prdata = 32'(r_channel_count);
            REG_INTERPOLATE:   prdata = 32'(r_interp);
            default:           prdata = '0;
        endcase
    end

    assign w_cfg.rows   = (r_row_count > ROWS_W'(TABLE_ROWS)) ? ROWS_W'(TABLE_ROWS)
                                                              : r_row_count;
    assign w_cfg.chans  = (r_channel_count > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                                   : r_channel_count;
    assign w_cfg.interp = r_interp;

    tsil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (s_axis_tvalid),
        .i_in_mode  (s_axis_tuser),
        .i_in_row   (s_axis_tdata[9:0]),
        .i_in_col   (s_axis_tdata[14:10]),
        .i_out_ready(m_axis_tready),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_last (m_axis_tlast),
        .o_cmd      (w_cmd)
    );

    tsil_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_entry_value(s_axis_tdata[46:15]),
        .i_query_time (s_axis_tdata[78:47]),
        .o_sts        (w_sts),
        .o_sample     (w_sample)
    );

    assign m_axis_tdata = {4'b0, w_sample, w_cmd.idx};

endmodule

FILE: sv/tsil_chk.sv
module tsil_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    default disable iff (!i_rst_n);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // No new item is taken while results are still being delivered.
    a_one_item: assert property (@(posedge i_clk)
        !(m_axis_tvalid && s_axis_tready))
        else $error("input accepted while results pending");

    // Channels of one query come out in ascending order without gaps.
    a_chan_seq: assert property (@(posedge i_clk)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1))
        else $error("channel sequence broken");

    // A table load produces no result.
    a_load_silent: assert property (@(posedge i_clk)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !m_axis_tvalid)
        else $error("result after a load beat");

    // The first result of a query is channel zero.
    a_first_chan: assert property (@(posedge i_clk)
        $rose(m_axis_tvalid) |-> m_axis_tdata[3:0] == 4'd0)
        else $error("first result is not channel zero");

endmodule

bind time_series_interp_lookup tsil_chk u_chk (.*);
